// ----- design/bcsc_pkg.sv -----
// Package for the barometric convert sequencer and compensation core.
// Widths, register indexes, command codes, sequencer op and step codes.
// No dependencies; every other design file imports it.
package bcsc_pkg;

   localparam int CoefW   = 16;
   localparam int OsrW    = 3;
   localparam int NowW    = 32;
   localparam int AdcW    = 24;
   localparam int TempW   = 19;
   localparam int PresW   = 32;
   localparam int CmdW    = 8;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 16;
   localparam int DelayW  = 4;

   // datapath widths
   localparam int DtW    = 25;   // D2 - C5*256
   localparam int MulW   = 25;   // signed multiplier operand
   localparam int ProdW  = 50;   // registered product
   localparam int TempIW = 20;   // working temperature
   localparam int WideW  = 40;   // OFF and SENS
   localparam int T2W    = 18;
   localparam int LoW    = 44;   // D1 * low SENS slice
   localparam int SumW   = 64;   // D1 * SENS
   localparam int QW     = 48;   // D1*SENS/2^21 - OFF

   localparam int OpW   = 3;
   localparam int StepW = 4;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_PRESSURE_SENS   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_PRESSURE_OFFSET = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SENS_TEMPCO     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_TEMPCO   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_REF_TEMP        = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_TEMP_SLOPE      = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_OSR_SELECT      = 3'd6;

   localparam logic [CmdW-1:0] CMD_CONV_PRES = 8'h40;
   localparam logic [CmdW-1:0] CMD_CONV_TEMP = 8'h50;

   localparam logic [OsrW-1:0] OSR_MAX = 3'd4;

   // datapath ops
   localparam logic [OpW-1:0] OP_NONE   = 3'd0;
   localparam logic [OpW-1:0] OP_CMD_P  = 3'd1;
   localparam logic [OpW-1:0] OP_CMD_T  = 3'd2;
   localparam logic [OpW-1:0] OP_WAIT   = 3'd3;
   localparam logic [OpW-1:0] OP_LOAD_T = 3'd4;
   localparam logic [OpW-1:0] OP_COMMIT = 3'd5;

   // compensation steps, one per cycle
   localparam logic [StepW-1:0] STEP_IDLE     = 4'd0;
   localparam logic [StepW-1:0] STEP_TEMP_MUL = 4'd1;
   localparam logic [StepW-1:0] STEP_OFF_MUL  = 4'd2;
   localparam logic [StepW-1:0] STEP_SENS_MUL = 4'd3;
   localparam logic [StepW-1:0] STEP_DTSQ_MUL = 4'd4;
   localparam logic [StepW-1:0] STEP_AUX_MUL  = 4'd5;
   localparam logic [StepW-1:0] STEP_SECOND   = 4'd6;
   localparam logic [StepW-1:0] STEP_PLO_MUL  = 4'd7;
   localparam logic [StepW-1:0] STEP_PHI_MUL  = 4'd8;
   localparam logic [StepW-1:0] STEP_PSUM     = 4'd9;
   localparam logic [StepW-1:0] STEP_PDIV     = 4'd10;
   localparam logic [StepW-1:0] STEP_FIRST    = STEP_TEMP_MUL;
   localparam logic [StepW-1:0] STEP_LAST     = STEP_PDIV;

   typedef struct packed {
      logic [OpW-1:0]   op;
      logic [StepW-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic elapsed;
   } dp_stat_type;

   // unused select codes fall back to the fastest setting
   function automatic logic [OsrW-1:0] osr_code(input logic [OsrW-1:0] sel);
      return (sel <= OSR_MAX) ? sel : '0;
   endfunction

   function automatic logic [DelayW-1:0] osr_delay(input logic [OsrW-1:0] code);
      logic [DelayW-1:0] d;
      case (code)
         3'd0:    d = 4'd1;
         3'd1:    d = 4'd2;
         3'd2:    d = 4'd3;
         3'd3:    d = 4'd5;
         3'd4:    d = 4'd10;
         default: d = 4'd1;
      endcase
      return d;
   endfunction

   function automatic logic [CmdW-1:0] conv_cmd(input logic [CmdW-1:0] base,
                                                input logic [OsrW-1:0] code);
      return base + {{(CmdW-OsrW-1){1'b0}}, code, 1'b0};
   endfunction

endpackage

// ----- design/bcsc_if.sv -----
// Channel interfaces of the barometric convert core: poll request and result.
// Depends on bcsc_pkg for field widths.
interface bcsc_req_if;
   import bcsc_pkg::*;

   logic            valid;
   logic            ready;
   logic [NowW-1:0] now_ms;
   logic [AdcW-1:0] adc_word;

   modport source (output valid, output now_ms, output adc_word, input ready);
   modport sink   (input valid, input now_ms, input adc_word, output ready);
endinterface

interface bcsc_rsp_if;
   import bcsc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    cmd_valid;
   logic [CmdW-1:0]         cmd_byte;
   logic                    adc_read;
   logic                    done_res;
   logic signed [TempW-1:0] temperature;
   logic signed [PresW-1:0] pressure;

   modport source (output valid, output cmd_valid, output cmd_byte, output adc_read,
                   output done_res, output temperature, output pressure, input ready);
   modport sink   (input valid, input cmd_valid, input cmd_byte, input adc_read,
                   input done_res, input temperature, input pressure, output ready);
endinterface

// ----- design/bcsc_ctrl.sv -----
// Controller of the barometric convert core: sequencer phase, step counter,
// request/result handshake. Depends on bcsc_pkg; drives bcsc_dp by commands.
module bcsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bcsc_pkg::dp_stat_type stat,
   output bcsc_pkg::dp_cmd_type  cmd
);
   import bcsc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   localparam logic [1:0] PH_ISSUE  = 2'd0;
   localparam logic [1:0] PH_WAIT_P = 2'd1;
   localparam logic [1:0] PH_WAIT_T = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free, accept, load_rsp;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      load_rsp = 1'b0;
      cmd.op   = OP_NONE;
      cmd.step = (state_ff == S_CALC) ? step_ff : STEP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  PH_WAIT_P: begin
                     load_rsp = 1'b1;
                     if (stat.elapsed) begin
                        cmd.op   = OP_CMD_T;
                        phase_in = PH_WAIT_T;
                     end else begin
                        cmd.op = OP_WAIT;
                     end
                  end
                  PH_WAIT_T: begin
                     if (stat.elapsed) begin
                        cmd.op   = OP_LOAD_T;
                        phase_in = PH_ISSUE;
                        state_in = S_CALC;
                        step_in  = STEP_FIRST;
                     end else begin
                        cmd.op   = OP_WAIT;
                        load_rsp = 1'b1;
                     end
                  end
                  // unreachable phase code behaves as issue
                  default: begin
                     cmd.op   = OP_CMD_P;
                     phase_in = PH_WAIT_P;
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         S_CALC: begin
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_LAST) begin
               state_in = S_FIN;
               step_in  = STEP_IDLE;
            end
         end
         S_FIN: begin
            // results overwrite the shown values, so wait for the slot
            if (slot_free) begin
               cmd.op   = OP_COMMIT;
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ISSUE;
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/bcsc_dp.sv -----
// Datapath of the barometric convert core: calibration registers, timing,
// shared 25x25 multiplier and the compensation registers. Depends on bcsc_pkg.
module bcsc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bcsc_pkg::dp_cmd_type          cmd,
   output bcsc_pkg::dp_stat_type         stat,
   input  logic [bcsc_pkg::NowW-1:0]     now_ms,
   input  logic [bcsc_pkg::AdcW-1:0]     adc_word,
   input  logic                          csr_wr_en,
   input  logic [bcsc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [bcsc_pkg::CsrW-1:0]     csr_wdata,
   output logic                          out_cmd_valid,
   output logic [bcsc_pkg::CmdW-1:0]     out_cmd_byte,
   output logic                          out_adc_read,
   output logic                          out_done_res,
   output logic [bcsc_pkg::TempW-1:0]    out_temperature,
   output logic [bcsc_pkg::PresW-1:0]    out_pressure
);
   import bcsc_pkg::*;

   localparam logic [ProdW-1:0] Bias23 = ProdW'((64'd1 << 23) - 64'd1);
   localparam logic [ProdW-1:0] Bias7  = ProdW'((64'd1 << 7) - 64'd1);
   localparam logic [ProdW-1:0] Bias8  = ProdW'((64'd1 << 8) - 64'd1);
   localparam logic [SumW-1:0]  Bias21 = SumW'((64'd1 << 21) - 64'd1);
   localparam logic [QW-1:0]    Bias15 = QW'((64'd1 << 15) - 64'd1);
   localparam logic [TempIW-1:0] TempRef = TempIW'(2000);

   logic [CoefW-1:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic [OsrW-1:0]  osr_ff;
   logic [NowW-1:0]  start_ms_ff;
   logic [AdcW-1:0]  raw_p_ff;
   logic [TempW-1:0] last_temp_ff;
   logic [PresW-1:0] last_pres_ff;

   logic [DtW-1:0]    dt_ff;
   logic [ProdW-1:0]  prod_ff;
   logic [TempIW-1:0] temp_ff;
   logic [WideW-1:0]  off_ff, sens_ff;
   logic [T2W-1:0]    t2_ff;
   logic [LoW-1:0]    lo_ff;
   logic [SumW-1:0]   pfull_ff;
   logic [QW-1:0]     q_ff;

   logic              cmd_valid_ff;
   logic [CmdW-1:0]   cmd_byte_ff;
   logic              adc_read_ff, done_ff;

   logic [OsrW-1:0]        osr_c;
   logic [NowW-1:0]        since;
   logic signed [MulW-1:0] mul_a, mul_b;
   logic signed [ProdW-1:0] mul_p;
   logic [TempIW:0]        tdiff;
   logic [ProdW-1:0]       div23, div7, div8;
   logic [34:0]            aux;
   logic [37:0]            five_aux;
   logic [SumW-1:0]        div21;
   logic [QW-1:0]          div15;
   logic                   below_ref;

   assign osr_c        = osr_code(osr_ff);
   assign since        = now_ms - start_ms_ff;
   assign stat.elapsed = since > NowW'(osr_delay(osr_c));

   assign tdiff = {temp_ff[TempIW-1], temp_ff} - {1'b0, TempRef};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         STEP_TEMP_MUL: begin
            mul_a = dt_ff;
            mul_b = {{(MulW-CoefW){1'b0}}, c6_ff};
         end
         STEP_OFF_MUL: begin
            mul_a = dt_ff;
            mul_b = {{(MulW-CoefW){1'b0}}, c4_ff};
         end
         STEP_SENS_MUL: begin
            mul_a = dt_ff;
            mul_b = {{(MulW-CoefW){1'b0}}, c3_ff};
         end
         STEP_DTSQ_MUL: begin
            mul_a = dt_ff;
            mul_b = dt_ff;
         end
         STEP_AUX_MUL: begin
            mul_a = {{(MulW-TempIW-1){tdiff[TempIW]}}, tdiff};
            mul_b = {{(MulW-TempIW-1){tdiff[TempIW]}}, tdiff};
         end
         STEP_PLO_MUL: begin
            mul_a = {1'b0, raw_p_ff};
            mul_b = {{(MulW-20){1'b0}}, sens_ff[19:0]};
         end
         STEP_PHI_MUL: begin
            mul_a = {1'b0, raw_p_ff};
            mul_b = {{(MulW-20){sens_ff[WideW-1]}}, sens_ff[WideW-1:20]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // signed division by 2^k rounding toward zero: bias negatives, then slice
   assign div23 = prod_ff + (prod_ff[ProdW-1] ? Bias23 : '0);
   assign div7  = prod_ff + (prod_ff[ProdW-1] ? Bias7 : '0);
   assign div8  = prod_ff + (prod_ff[ProdW-1] ? Bias8 : '0);
   assign div21 = pfull_ff + (pfull_ff[SumW-1] ? Bias21 : '0);
   assign div15 = q_ff + (q_ff[QW-1] ? Bias15 : '0);

   assign aux       = prod_ff[34:0];
   assign five_aux  = {1'b0, aux, 2'b00} + {3'b000, aux};
   assign below_ref = $signed(temp_ff) < $signed(TempRef);

   // calibration and osr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff  <= '0;
         c2_ff  <= '0;
         c3_ff  <= '0;
         c4_ff  <= '0;
         c5_ff  <= '0;
         c6_ff  <= '0;
         osr_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESSURE_SENS:   c1_ff  <= csr_wdata;
            CSR_PRESSURE_OFFSET: c2_ff  <= csr_wdata;
            CSR_SENS_TEMPCO:     c3_ff  <= csr_wdata;
            CSR_OFFSET_TEMPCO:   c4_ff  <= csr_wdata;
            CSR_REF_TEMP:        c5_ff  <= csr_wdata;
            CSR_TEMP_SLOPE:      c6_ff  <= csr_wdata;
            CSR_OSR_SELECT:      osr_ff <= csr_wdata[OsrW-1:0];
            default: ;
         endcase
      end
   end

   // sequencer state held across polls
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ms_ff  <= '0;
         raw_p_ff     <= '0;
         last_temp_ff <= '0;
         last_pres_ff <= '0;
      end else begin
         case (cmd.op)
            OP_CMD_P: start_ms_ff <= now_ms;
            OP_CMD_T: begin
               start_ms_ff <= now_ms;
               raw_p_ff    <= adc_word;
            end
            OP_COMMIT: begin
               last_temp_ff <= temp_ff[TempW-1:0];
               last_pres_ff <= div15[PresW+14:15];
            end
            default: ;
         endcase
      end
   end

   // result flags
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CMD_P: begin
            cmd_valid_ff <= 1'b1;
            cmd_byte_ff  <= conv_cmd(CMD_CONV_PRES, osr_c);
            adc_read_ff  <= 1'b0;
            done_ff      <= 1'b0;
         end
         OP_CMD_T: begin
            cmd_valid_ff <= 1'b1;
            cmd_byte_ff  <= conv_cmd(CMD_CONV_TEMP, osr_c);
            adc_read_ff  <= 1'b1;
            done_ff      <= 1'b0;
         end
         OP_WAIT: begin
            cmd_valid_ff <= 1'b0;
            cmd_byte_ff  <= '0;
            adc_read_ff  <= 1'b0;
            done_ff      <= 1'b0;
         end
         OP_COMMIT: begin
            cmd_valid_ff <= 1'b0;
            cmd_byte_ff  <= '0;
            adc_read_ff  <= 1'b1;
            done_ff      <= 1'b1;
         end
         default: ;
      endcase
   end

   // compensation sequence
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (cmd.op == OP_LOAD_T) begin
         dt_ff <= {1'b0, adc_word} - {1'b0, c5_ff, 8'h00};
      end
      case (cmd.step)
         STEP_OFF_MUL:  temp_ff <= TempRef + div23[TempIW+22:23];
         STEP_SENS_MUL: off_ff  <= {{(WideW-CoefW-16){1'b0}}, c2_ff, 16'h0000}
                                   + div7[WideW+6:7];
         STEP_DTSQ_MUL: sens_ff <= {{(WideW-CoefW-15){1'b0}}, c1_ff, 15'h0000}
                                   + div8[WideW+7:8];
         STEP_AUX_MUL:  t2_ff   <= prod_ff[48:31];
         STEP_SECOND: begin
            if (below_ref) begin
               temp_ff <= temp_ff - {{(TempIW-T2W){1'b0}}, t2_ff};
               off_ff  <= off_ff - {{(WideW-37){1'b0}}, five_aux[37:1]};
               sens_ff <= sens_ff - {{(WideW-36){1'b0}}, five_aux[37:2]};
            end
         end
         STEP_PHI_MUL:  lo_ff    <= prod_ff[LoW-1:0];
         STEP_PSUM:     pfull_ff <= {prod_ff[LoW-1:0], 20'h00000}
                                    + {{(SumW-LoW){1'b0}}, lo_ff};
         // quotient by 2^21 is sign-extended up to the working width
         STEP_PDIV:     q_ff     <= {{(QW-SumW+21){div21[SumW-1]}}, div21[SumW-1:21]}
                                    - {{(QW-WideW){off_ff[WideW-1]}}, off_ff};
         default: ;
      endcase
   end

   assign out_cmd_valid   = cmd_valid_ff;
   assign out_cmd_byte    = cmd_byte_ff;
   assign out_adc_read    = adc_read_ff;
   assign out_done_res    = done_ff;
   assign out_temperature = last_temp_ff;
   assign out_pressure    = last_pres_ff;

endmodule

// ----- design/baro_convert_sequencer_compensation_core.sv -----
// Top level of the barometric convert sequencer with second-order compensation.
// Depends on bcsc_pkg, bcsc_if, bcsc_ctrl and bcsc_dp.
//
//   port      dir   kind             contents
//   req_ch    in    valid/ready      now_ms, adc_word (one poll)
//   rsp_ch    out   valid/ready      cmd_valid, cmd_byte, adc_read, done_res,
//                                    temperature, pressure
//   csr_*     in    write only       wr_en, index 0..6, 16-bit data
//
// A poll that issues a command or waits yields its result in the cycle after transfer.
// A poll that reads the temperature word yields its result after ten compensation steps,
// the multiplies among them through the one shared 25x25 multiplier, then a commit step.
// One poll at a time; the next is taken once the sequencer is idle and no result
// is pending, or in the cycle the pending one transfers. A stalled result holds;
// reset is synchronous, active high.
module baro_convert_sequencer_compensation_core (
   input  logic                          clock,
   input  logic                          reset,
   bcsc_req_if.sink                      req_ch,
   bcsc_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bcsc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [bcsc_pkg::CsrW-1:0]     csr_wdata
);
   import bcsc_pkg::*;

   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [TempW-1:0] temp_bits;
   logic [PresW-1:0] pres_bits;

   bcsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bcsc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .now_ms          (req_ch.now_ms),
      .adc_word        (req_ch.adc_word),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .out_cmd_valid   (rsp_ch.cmd_valid),
      .out_cmd_byte    (rsp_ch.cmd_byte),
      .out_adc_read    (rsp_ch.adc_read),
      .out_done_res    (rsp_ch.done_res),
      .out_temperature (temp_bits),
      .out_pressure    (pres_bits)
   );

   assign rsp_ch.temperature = $signed(temp_bits);
   assign rsp_ch.pressure    = $signed(pres_bits);

endmodule

// ----- design/bcsc_checker.sv -----
// Port-level checks for the barometric convert core, bound to the top level.
// Depends on bcsc_pkg for widths.
module bcsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          cmd_valid,
   input logic [bcsc_pkg::CmdW-1:0]     cmd_byte,
   input logic                          adc_read,
   input logic                          done_res,
   input logic [bcsc_pkg::TempW-1:0]    temperature,
   input logic [bcsc_pkg::PresW-1:0]    pressure
);
   import bcsc_pkg::*;

   // a finished computation always consumed the ADC and sent no command
   a_done_reads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> adc_read && !cmd_valid)
      else $error("done_res without adc_read or with a command");

   a_no_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cmd_valid |-> cmd_byte == '0)
      else $error("cmd_byte set without cmd_valid");

   // compensated values move only together with a fresh result
   a_values_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> $stable(temperature) && $stable(pressure))
      else $error("temperature or pressure changed without done_res");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cmd_byte) && $stable(done_res))
      else $error("stalled result dropped or changed");

endmodule

bind baro_convert_sequencer_compensation_core bcsc_checker u_bcsc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .cmd_valid   (rsp_ch.cmd_valid),
   .cmd_byte    (rsp_ch.cmd_byte),
   .adc_read    (rsp_ch.adc_read),
   .done_res    (rsp_ch.done_res),
   .temperature (rsp_ch.temperature),
   .pressure    (rsp_ch.pressure)
);

// ----- bench/tb.sv -----
// Testbench for baro_convert_sequencer_compensation_core: a directed table, then
// random polls and calibration changes, each result checked against a local predictor or known value.
// Depends on bcsc_pkg, bcsc_if and the core itself.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bcsc_pkg::*;

   localparam int                   LIMIT_CYCLES = 400_000;
   localparam int                   SETTLE       = 16;
   localparam logic [CsrIdxW-1:0]   CSR_UNUSED   = 3'd7;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_WAIT_PRES, SEQ_WAIT_TEMP} seq_phase_e;
   typedef enum logic [1:0] {ROW_POLL, ROW_KNOWN, ROW_CSR} row_kind_e;

   typedef struct packed {
      logic                    cmd_valid;
      logic [CmdW-1:0]         cmd_byte;
      logic                    adc_read;
      logic                    done_res;
      logic signed [TempW-1:0] temperature;
      logic signed [PresW-1:0] pressure;
   } poll_result_t;

   typedef struct packed {
      row_kind_e         kind;
      logic [CsrIdxW-1:0] idx;
      logic [CsrW-1:0]   wdata;
      logic [NowW-1:0]   now;
      logic [AdcW-1:0]   adc;
      poll_result_t      known;
   } stim_row_t;

   logic clock;
   logic reset;
   logic               csr_wr_en;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0]    csr_wdata;

   bcsc_req_if req_ch();
   bcsc_rsp_if rsp_ch();

   baro_convert_sequencer_compensation_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [CoefW-1:0]        cal [6];
   logic [OsrW-1:0]         osr_sel;
   seq_phase_e              seq_phase;
   logic [NowW-1:0]         start_ms;
   logic [AdcW-1:0]         held_pressure;
   logic signed [TempW-1:0] last_temp;
   logic signed [PresW-1:0] last_pres;

   poll_result_t expected_results[$];
   poll_result_t oldest;
   stim_row_t    directed_rows[$];

   int fails;
   int polls_sent;
   int results_checked;
   int computations;
   int cold_computations;
   int csr_writes;
   int cycles;
   int tx_idle_pct;
   int rx_idle_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic logic [OsrW-1:0] active_osr();
      return (osr_sel <= OSR_MAX) ? osr_sel : '0;
   endfunction

   function automatic logic [NowW-1:0] wait_ms_for(input logic [OsrW-1:0] code);
      case (code)
         3'd1:    return 32'd2;
         3'd2:    return 32'd3;
         3'd3:    return 32'd5;
         3'd4:    return 32'd10;
         default: return 32'd1;
      endcase
   endfunction

   // second-order compensation, 64-bit signed, divisions truncate toward zero
   function automatic void compensate(input logic [AdcW-1:0] d1, input logic [AdcW-1:0] d2);
      longint dt, tmp, off, sens, t2, aux, p;
      dt   = longint'(d2) - longint'(cal[4]) * 256;
      tmp  = 2000 + (dt * longint'(cal[5])) / 8388608;
      off  = longint'(cal[1]) * 65536 + (longint'(cal[3]) * dt) / 128;
      sens = longint'(cal[0]) * 32768 + (longint'(cal[2]) * dt) / 256;
      if (tmp < 2000) begin
         t2   = (dt * dt) >>> 31;
         aux  = (tmp - 2000) * (tmp - 2000);
         tmp  = tmp - t2;
         off  = off - ((5 * aux) >>> 1);
         sens = sens - ((5 * aux) >>> 2);
         cold_computations++;
      end
      p = (longint'(d1) * sens / 2097152 - off) / 32768;
      last_temp = tmp[TempW-1:0];
      last_pres = p[PresW-1:0];
      computations++;
   endfunction

   function automatic poll_result_t step_sequencer(input logic [NowW-1:0] now,
                                                   input logic [AdcW-1:0] adc);
      poll_result_t     r;
      logic [OsrW-1:0]  code;
      logic [NowW-1:0]  since;
      logic             elapsed;
      code    = active_osr();
      since   = now - start_ms;
      elapsed = since > wait_ms_for(code);
      r       = '0;
      case (seq_phase)
         SEQ_WAIT_PRES: begin
            if (elapsed) begin
               held_pressure = adc;
               r.adc_read    = 1'b1;
               r.cmd_valid   = 1'b1;
               r.cmd_byte    = CMD_CONV_TEMP + {code, 1'b0};
               start_ms      = now;
               seq_phase     = SEQ_WAIT_TEMP;
            end
         end
         SEQ_WAIT_TEMP: begin
            if (elapsed) begin
               r.adc_read = 1'b1;
               compensate(held_pressure, adc);
               r.done_res = 1'b1;
               seq_phase  = SEQ_IDLE;
            end
         end
         default: begin
            r.cmd_valid = 1'b1;
            r.cmd_byte  = CMD_CONV_PRES + {code, 1'b0};
            start_ms    = now;
            seq_phase   = SEQ_WAIT_PRES;
         end
      endcase
      r.temperature = last_temp;
      r.pressure    = last_pres;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            fails++;
         end else begin
            oldest = expected_results.pop_front();
            check_field("cmd_valid", oldest.cmd_valid, rsp_ch.cmd_valid);
            check_field("cmd_byte", oldest.cmd_byte, rsp_ch.cmd_byte);
            check_field("adc_read", oldest.adc_read, rsp_ch.adc_read);
            check_field("done_res", oldest.done_res, rsp_ch.done_res);
            check_field("temperature", oldest.temperature, rsp_ch.temperature);
            check_field("pressure", oldest.pressure, rsp_ch.pressure);
         end
      end
   end

   // one poll transfer; a typed expectation replaces the predicted one
   task automatic drive_poll(input logic [NowW-1:0] now, input logic [AdcW-1:0] adc,
                             input bit typed, input poll_result_t given);
      poll_result_t r;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.now_ms   <= now;
      req_ch.adc_word <= adc;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      r = step_sequencer(now, adc);
      expected_results.push_back(typed ? given : r);
      polls_sent++;
   endtask

   // stop sending and let every outstanding result and the datapath drain
   task automatic settle_block();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrW-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx <= CSR_TEMP_SLOPE)
         cal[idx] = data;
      else if (idx == CSR_OSR_SELECT)
         osr_sel = data[OsrW-1:0];
      csr_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CoefW-1:0] pick_coef();
      case ($urandom_range(9))
         0:          return '0;
         1:          return 16'hFFFF;
         2, 3, 4, 5: return 16'($urandom_range(20000, 50000));
         default:    return 16'($urandom);
      endcase
   endfunction

   task automatic reconfigure();
      for (int i = 0; i <= int'(CSR_TEMP_SLOPE); i++)
         write_reg(3'(i), pick_coef());
      // upper data bits are don't-care for the select register
      write_reg(CSR_OSR_SELECT, {13'($urandom), 3'($urandom_range(7))});
      if ($urandom_range(3) == 0)
         write_reg(CSR_UNUSED, 16'($urandom));
   endtask

   task automatic add_poll(input logic [NowW-1:0] now, input logic [AdcW-1:0] adc);
      directed_rows.push_back('{ROW_POLL, '0, '0, now, adc, '0});
   endtask

   task automatic add_known(input logic [NowW-1:0] now, input logic [AdcW-1:0] adc,
                            input poll_result_t known);
      directed_rows.push_back('{ROW_KNOWN, '0, '0, now, adc, known});
   endtask

   task automatic add_write(input logic [CsrIdxW-1:0] idx, input logic [CsrW-1:0] data);
      directed_rows.push_back('{ROW_CSR, idx, data, '0, '0, '0});
   endtask

   initial begin
      stim_row_t       row;
      bit              busy;
      logic [NowW-1:0] tick;
      logic [AdcW-1:0] adc;
      int              polls_left;
      int              run_len;
      int              pick;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.now_ms   = '0;
      req_ch.adc_word = '0;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      tx_idle_pct     = 0;
      rx_idle_pct     = 0;
      fails           = 0;
      foreach (cal[i]) cal[i] = '0;
      osr_sel       = '0;
      seq_phase     = SEQ_IDLE;
      start_ms      = '0;
      held_pressure = '0;
      last_temp     = '0;
      last_pres     = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all coefficients zero after reset: results readable by eye
      add_known(32'd0, 24'd0, '{1'b1, CMD_CONV_PRES, 1'b0, 1'b0, 19'sd0, 32'sd0});
      add_known(32'd1, 24'hFFFFFF, '{1'b0, 8'd0, 1'b0, 1'b0, 19'sd0, 32'sd0});
      add_known(32'd2, 24'hFFFFFF, '{1'b1, CMD_CONV_TEMP, 1'b1, 1'b0, 19'sd0, 32'sd0});
      add_known(32'd4, 24'd0, '{1'b0, 8'd0, 1'b1, 1'b1, 19'sd2000, 32'sd0});
      // typical calibration, slowest oversampling, tick wrapping during a wait
      add_write(CSR_PRESSURE_SENS, 16'd40127);
      add_write(CSR_PRESSURE_OFFSET, 16'd36924);
      add_write(CSR_SENS_TEMPCO, 16'd23317);
      add_write(CSR_OFFSET_TEMPCO, 16'd23282);
      add_write(CSR_REF_TEMP, 16'd33464);
      add_write(CSR_TEMP_SLOPE, 16'd28312);
      add_write(CSR_OSR_SELECT, 16'd4);
      add_poll(32'hFFFF_FFF8, 24'd0);
      add_poll(32'd2, 24'd5);
      add_poll(32'd3, 24'd9085466);
      add_poll(32'd13, 24'd7);
      add_poll(32'd14, 24'd8569150);
      add_poll(32'd20, 24'd0);
      add_poll(32'd31, 24'd9085466);
      add_poll(32'd42, 24'd0);
      add_poll(32'd50, 24'd0);
      add_poll(32'd61, 24'hFFFFFF);
      add_poll(32'd72, 24'hFFFFFF);
      // full-scale coefficients; select 7 falls back to the fastest setting
      for (int i = 0; i <= int'(CSR_TEMP_SLOPE); i++)
         add_write(3'(i), 16'hFFFF);
      add_write(CSR_OSR_SELECT, 16'hFFFF);
      add_write(CSR_UNUSED, 16'hFFFF);
      add_poll(32'd100, 24'd0);
      add_poll(32'd101, 24'd0);
      add_poll(32'd102, 24'hFFFFFF);
      add_poll(32'd104, 24'd0);
      add_poll(32'd110, 24'd0);
      add_poll(32'd112, 24'd0);
      add_poll(32'd114, 24'hFFFFFF);

      busy = 1'b0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            if (busy) settle_block();
            busy = 1'b0;
            write_reg(row.idx, row.wdata);
         end else begin
            drive_poll(row.now, row.adc, row.kind == ROW_KNOWN, row.known);
            busy = 1'b1;
         end
      end

      tick = 32'd200;
      for (int ph = 0; ph < 3; ph++) begin
         // settle first: the receiver's rate must not change under a result
         settle_block();
         case (ph)
            0:       begin tx_idle_pct = 8;  rx_idle_pct = 56; end
            1:       begin tx_idle_pct = 56; rx_idle_pct = 8;  end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         polls_left = 184;
         while (polls_left > 0) begin
            settle_block();
            reconfigure();
            run_len = $urandom_range(15, 60);
            if (run_len > polls_left) run_len = polls_left;
            repeat (run_len) begin
               pick = $urandom_range(99);
               if (pick < 4)
                  tick = $urandom;
               else if (pick < 7)
                  tick = 32'hFFFF_FFFF - 32'($urandom_range(12));
               else if (pick < 9)
                  tick = tick - 32'($urandom_range(1, 50));
               else
                  tick = tick + 32'($urandom_range(0, 12));
               pick = $urandom_range(99);
               if (pick < 10)
                  adc = '0;
               else if (pick < 20)
                  adc = 24'hFFFFFF;
               else if (pick < 50 && seq_phase == SEQ_WAIT_TEMP)
                  // near the reference temperature, both sides of 20.00 C
                  adc = {cal[4], 8'h00} + 24'($urandom_range(0, 4000)) - 24'd2000;
               else
                  adc = 24'($urandom);
               drive_poll(tick, adc, 1'b0, '0);
            end
            polls_left -= run_len;
         end
      end

      settle_block();
      $display("polls %0d, results checked %0d, register writes %0d", polls_sent,
               results_checked, csr_writes);
      $display("compensations %0d, of which %0d below 20 C", computations,
               cold_computations);
      if (fails == 0 && expected_results.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/bcsc_pkg.sv
design/bcsc_if.sv
design/bcsc_ctrl.sv
design/bcsc_dp.sv
design/baro_convert_sequencer_compensation_core.sv
design/bcsc_checker.sv
bench/tb.sv
